// File: rtl/charge_to_tot_quantized_macros.svh
// Assertion macros for the time-over-threshold digitizer.
`ifndef CHARGE_TO_TOT_QUANTIZED_MACROS_SVH
`define CHARGE_TO_TOT_QUANTIZED_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C2TOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define C2TOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/c2tot_pkg.sv
// Package with widths, register indexes and defaults of the digitizer.
package c2tot_pkg;
    localparam int CHARGE_W = 24;
    localparam int TIME_W = 16;
    localparam int CUR_W = 10;
    localparam int TOT_W = 29;
    localparam int CFG_W = 24;
    localparam int IDX_W = 2;
    localparam int Q_W = 28;
    localparam int T_W = 29;

    localparam logic [IDX_W-1:0] REG_RISE = 2'd0;
    localparam logic [IDX_W-1:0] REG_CURRENT = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd2;
    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd3;

    localparam logic [TIME_W-1:0] RST_RISE = 16'd1600;
    localparam logic [CUR_W-1:0] RST_CURRENT = 10'd60;
    localparam logic [CHARGE_W-1:0] RST_THRESHOLD = 24'd3000;
    localparam logic [TIME_W-1:0] RST_PERIOD = 16'd320;
    localparam logic [CUR_W-1:0] DEFAULT_CURRENT = 10'd60;
endpackage

// File: rtl/charge_to_tot_quantized.sv
// Top level of the clock-quantized time-over-threshold digitizer.
// Takes one hit request per cycle while not stalled; returns one result per hit, in order,
// via two input stages, two 28-stage dividers for the crossing times, a crossing-time
// stage, two 29-stage dividers for clock quantization and two output stages. An output
// stall freezes it; the user must write configuration while it is empty, not enforced.
module charge_to_tot_quantized (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [c2tot_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [c2tot_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [c2tot_pkg::CHARGE_W-1:0] i_charge_e,
    input  logic [c2tot_pkg::TIME_W-1:0]  i_phase_offset_q4,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [c2tot_pkg::TOT_W-1:0]   o_tot_q4,
    output logic                          o_below_threshold
);
    localparam int CW = c2tot_pkg::CHARGE_W;
    localparam int TW = c2tot_pkg::TIME_W;
    localparam int UW = c2tot_pkg::CUR_W;
    localparam int QW = c2tot_pkg::Q_W;
    localparam int XW = c2tot_pkg::T_W;
    localparam int S1W = 3 * TW + 1;
    localparam int S3W = TW + 1;

    logic [TW-1:0] r_rise;
    logic [UW-1:0] r_cur;
    logic [CW-1:0] r_thr;
    logic [TW-1:0] r_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise <= c2tot_pkg::RST_RISE;
            r_cur <= c2tot_pkg::RST_CURRENT;
            r_thr <= c2tot_pkg::RST_THRESHOLD;
            r_per <= c2tot_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                c2tot_pkg::REG_RISE:      r_rise <= i_cfg_data[TW-1:0];
                c2tot_pkg::REG_CURRENT:   r_cur <= i_cfg_data[UW-1:0];
                c2tot_pkg::REG_THRESHOLD: r_thr <= i_cfg_data[CW-1:0];
                c2tot_pkg::REG_PERIOD:    r_per <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Stage 0: apply the special cases.
    logic          n_below;
    logic          r0_v;
    logic [CW-1:0] r0_q;
    logic [CW-1:0] r0_qth;
    logic          r0_below;
    logic [UW-1:0] r0_cur;
    logic [TW-1:0] r0_per;
    logic [TW-1:0] r0_off;
    logic [TW-1:0] r0_rise;

    assign n_below = (i_charge_e <= r_thr) || (i_charge_e == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
        if (en) begin
            r0_q <= n_below ? CW'(1) : i_charge_e;
            r0_qth <= n_below ? CW'(1) : r_thr;
            r0_below <= n_below;
            r0_cur <= (r_cur == '0) ? c2tot_pkg::DEFAULT_CURRENT : r_cur;
            r0_per <= (r_per == '0) ? TW'(1) : r_per;
            r0_off <= i_phase_offset_q4;
            r0_rise <= r_rise;
        end
    end

    // Stage 1: numerators of both crossing times.
    logic              r1_v;
    logic [TW+CW-1:0]  r1_prod;
    logic [QW-1:0]     r1_n2;
    logic [CW-1:0]     r1_q;
    logic [UW-1:0]     r1_cur;
    logic [S1W-1:0]    r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
        if (en) begin
            r1_prod <= r0_rise * r0_qth;
            r1_n2 <= {r0_q - r0_qth, 4'b0};
            r1_q <= r0_q;
            r1_cur <= r0_cur;
            r1_side <= {r0_off, r0_rise, r0_per, r0_below};
        end
    end

    logic              d1_v;
    logic              d2_v;
    logic [QW-1:0]     d1_quo;
    logic [QW-1:0]     d2_quo;
    logic [S1W-1:0]    d1_side;
    logic              d2_side;

    c2tot_div #(.DW(CW), .QW(QW), .PW(S1W)) u_div_start (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r1_v),
        .i_num({(CW + QW - TW - CW)'(0), r1_prod}), .i_den(r1_q), .i_side(r1_side),
        .o_valid(d1_v), .o_quo(d1_quo), .o_side(d1_side)
    );

    c2tot_div #(.DW(UW), .QW(QW), .PW(1)) u_div_stop (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r1_v),
        .i_num({UW'(0), r1_n2}), .i_den(r1_cur), .i_side(r1_side[0]),
        .o_valid(d2_v), .o_quo(d2_quo), .o_side(d2_side)
    );

    // Stage 2: crossing times.
    logic          r2_v;
    logic [XW-1:0] r2_t1;
    logic [XW-1:0] r2_t2;
    logic [TW-1:0] r2_per;
    logic          r2_below;
    logic [TW-1:0] d_off;
    logic [TW-1:0] d_rise;

    assign d_off = d1_side[S1W-1 -: TW];
    assign d_rise = d1_side[2*TW : TW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= d1_v && d2_v;
        end
        if (en) begin
            r2_t1 <= XW'(d1_quo) + XW'(d_off);
            r2_t2 <= XW'(d2_quo) + XW'(d_rise) + XW'(d_off);
            r2_per <= d1_side[TW:1];
            r2_below <= d1_side[0] & d2_side;
        end
    end

    logic          k1_v;
    logic          k2_v;
    logic [XW-1:0] k1;
    logic [XW-1:0] k2;
    logic [S3W-1:0] k1_side;
    logic          k2_side;

    c2tot_div #(.DW(TW), .QW(XW), .PW(S3W)) u_quant_start (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_v),
        .i_num({TW'(0), r2_t1}), .i_den(r2_per), .i_side({r2_per, r2_below}),
        .o_valid(k1_v), .o_quo(k1), .o_side(k1_side)
    );

    c2tot_div #(.DW(TW), .QW(XW), .PW(1)) u_quant_stop (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_v),
        .i_num({TW'(0), r2_t2}), .i_den(r2_per), .i_side(r2_below),
        .o_valid(k2_v), .o_quo(k2), .o_side(k2_side)
    );

    // Stage 3: difference of clock counts. Stage 4: scale by the period.
    logic          r3_v;
    logic [XW-1:0] r3_diff;
    logic [TW-1:0] r3_per;
    logic          r3_below;
    logic [c2tot_pkg::TOT_W-1:0] r_tot;
    logic          r_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r3_v <= k1_v && k2_v;
            r_out_valid <= r3_v;
        end
        if (en) begin
            r3_diff <= k2 - k1;
            r3_per <= k1_side[S3W-1:1];
            r3_below <= k1_side[0] & k2_side;
            r_tot <= c2tot_pkg::TOT_W'(r3_diff * r3_per);
            r_below <= r3_below;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tot_q4 = r_tot;
    assign o_below_threshold = r_below;
endmodule

// File: rtl/c2tot_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module c2tot_div #(
    parameter int DW = 24,
    parameter int QW = 28,
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW+QW-1:0]  i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [PW-1:0]     i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quo,
    output logic [PW-1:0]     o_side
);
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_nq   [QW];
    logic [DW-1:0] r_den  [QW];
    logic [PW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] side_in;
        logic          vld_in;
        logic [DW:0]   sh;
        logic          ge;
        logic [DW:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = i_num[DW+QW-1:QW];
            assign nq_in = i_num[QW-1:0];
            assign den_in = i_den;
            assign side_in = i_side;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nq_in = r_nq[k-1];
            assign den_in = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign sh = {rem_in, nq_in[QW-1]};
        assign ge = (sh >= {1'b0, den_in});
        assign diff = sh - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
            if (i_en) begin
                r_rem[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_nq[k] <= {nq_in[QW-2:0], ge};
                r_den[k] <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo = r_nq[QW-1];
    assign o_side = r_side[QW-1];
endmodule

// File: rtl/c2tot_checker.sv
// Port-level checker for the digitizer, bound to the top level.
`include "charge_to_tot_quantized_macros.svh"

module c2tot_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [c2tot_pkg::TOT_W-1:0] o_tot_q4,
    input logic                        o_below_threshold
);
    `C2TOT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_tot_q4))
    `C2TOT_ASSERT_IMPL(a_below_zero, i_clk, i_rst_n, o_valid && o_below_threshold, o_tot_q4 == '0)
    `C2TOT_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
endmodule

bind charge_to_tot_quantized c2tot_checker u_c2tot_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_tot_q4(o_tot_q4),
    .o_below_threshold(o_below_threshold)
);

// File: tb/sv/testbench.sv
// Testbench for the clock-quantized time-over-threshold digitizer with a scoreboard.
`timescale 1ns / 100ps

class tot_scoreboard;
    bit [15:0] rise;
    bit [9:0]  current;
    bit [23:0] threshold;
    bit [15:0] period;
    bit [28:0] tot_queue[$];
    bit        below_queue[$];
    int        errors;

    function new();
        rise = c2tot_pkg::RST_RISE;
        current = c2tot_pkg::RST_CURRENT;
        threshold = c2tot_pkg::RST_THRESHOLD;
        period = c2tot_pkg::RST_PERIOD;
        errors = 0;
    endfunction

    function void set_register(logic [c2tot_pkg::IDX_W-1:0] idx, bit [23:0] value);
        case (idx)
            c2tot_pkg::REG_RISE: rise = value[15:0];
            c2tot_pkg::REG_CURRENT: current = value[9:0];
            c2tot_pkg::REG_THRESHOLD: threshold = value;
            c2tot_pkg::REG_PERIOD: period = value[15:0];
            default: ;
        endcase
    endfunction

    function bit [63:0] snap_to_clock(bit [63:0] t, bit [63:0] p);
        return (t / p) * p + p;
    endfunction

    function void note_hit(bit [23:0] charge, bit [15:0] offset);
        bit [63:0] q, qth, cur, p, t1, t2;
        bit        below;
        q = charge;
        qth = threshold;
        cur = (current == 0) ? 64'(c2tot_pkg::DEFAULT_CURRENT) : 64'(current);
        p = (period == 0) ? 64'd1 : 64'(period);
        below = 0;
        if (q <= qth || q == 0) begin
            q = 1;
            qth = 1;
            below = 1;
        end
        t1 = (64'(rise) * qth) / q + offset;
        t2 = ((q - qth) * 16) / cur + rise + offset;
        tot_queue.push_back(29'(snap_to_clock(t2, p) - snap_to_clock(t1, p)));
        below_queue.push_back(below);
    endfunction

    function void check_result(bit [28:0] tot, bit below);
        bit [28:0] exp_tot;
        bit        exp_below;
        if (tot_queue.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result: tot=%0d below=%0d", tot, below);
            return;
        end
        exp_tot = tot_queue.pop_front();
        exp_below = below_queue.pop_front();
        if (tot !== exp_tot || below !== exp_below) begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected tot=%0d below=%0d, got tot=%0d below=%0d",
                         exp_tot, exp_below, tot, below);
        end
    endfunction

    function int pending();
        return tot_queue.size();
    endfunction
endclass

module testbench;
    logic                           i_clk = 0;
    logic                           i_rst_n = 0;
    logic                           i_cfg_we = 0;
    logic [c2tot_pkg::IDX_W-1:0]    i_cfg_idx = '0;
    logic [c2tot_pkg::CFG_W-1:0]    i_cfg_data = '0;
    logic                           i_valid = 0;
    logic                           o_stall;
    logic [c2tot_pkg::CHARGE_W-1:0] i_charge_e = '0;
    logic [c2tot_pkg::TIME_W-1:0]   i_phase_offset_q4 = '0;
    logic                           o_valid;
    logic                           i_stall = 0;
    logic [c2tot_pkg::TOT_W-1:0]    o_tot_q4;
    logic                           o_below_threshold;

    tot_scoreboard scoreboard = new();
    bit            idle_on = 1;
    int            hold_cycles = 0;

    charge_to_tot_quantized u_dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            scoreboard.check_result(o_tot_q4, o_below_threshold);
        if (i_rst_n && i_valid && !o_stall)
            scoreboard.note_hit(i_charge_e, i_phase_offset_q4);
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < 37);
        end
    end

    task automatic write_register(logic [c2tot_pkg::IDX_W-1:0] idx,
                                  logic [c2tot_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        scoreboard.set_register(idx, value);
    endtask

    task automatic send_hit(logic [c2tot_pkg::CHARGE_W-1:0] charge,
                            logic [c2tot_pkg::TIME_W-1:0] offset);
        while (idle_on && $urandom_range(99) < 37) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_charge_e <= charge;
        i_phase_offset_q4 <= offset;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_valid <= 0;
        while (scoreboard.pending() > 0)
            @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    function automatic logic [c2tot_pkg::CHARGE_W-1:0] random_charge();
        case ($urandom_range(4))
            0: return 24'($urandom_range(scoreboard.threshold));
            1: return 24'($urandom);
            2: return 24'(scoreboard.threshold + $urandom_range(20000));
            default: return 24'(scoreboard.threshold + $urandom_range(500000));
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_hit(random_charge(),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400)));
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;

        send_hit(0, 0);
        send_hit(3000, 5);
        send_hit(3001, 0);
        send_hit(24'hFFFFFF, 16'hFFFF);
        send_hit(24'hFFFFFF, 0);
        send_hit(5000, 16'hFFFF);
        send_hit(100000, 319);
        send_hit(24'hAAAAAA, 16'h5555);
        send_hit(24'h555555, 16'hAAAA);
        drain_pipeline();

        write_register(c2tot_pkg::REG_CURRENT, 0);
        write_register(c2tot_pkg::REG_PERIOD, 0);
        write_register(c2tot_pkg::REG_RISE, 16'hFFFF);
        write_register(c2tot_pkg::REG_THRESHOLD, 0);
        send_hit(0, 0);
        send_hit(1, 7);
        send_hit(24'hFFFFFF, 16'hFFFF);
        random_phase(200);
        drain_pipeline();

        write_register(c2tot_pkg::REG_CURRENT, 10'h3FF);
        write_register(c2tot_pkg::REG_PERIOD, 16'hFFFF);
        write_register(c2tot_pkg::REG_RISE, 0);
        write_register(c2tot_pkg::REG_THRESHOLD, 24'hFFFFFF);
        send_hit(24'hFFFFFF, 16'hFFFF);
        drain_pipeline();
        write_register(c2tot_pkg::REG_THRESHOLD, 24'hFFFFFE);
        send_hit(24'hFFFFFF, 16'hFFFF);
        random_phase(100);
        drain_pipeline();

        write_register(c2tot_pkg::REG_CURRENT, 1);
        write_register(c2tot_pkg::REG_PERIOD, 1);
        write_register(c2tot_pkg::REG_RISE, 1600);
        write_register(c2tot_pkg::REG_THRESHOLD, 1000);
        idle_on = 0;
        random_phase(300);
        idle_on = 1;
        hold_cycles = 200;
        random_phase(150);
        drain_pipeline();

        for (int phase = 0; phase < 5; phase++) begin
            write_register(c2tot_pkg::REG_CURRENT, 24'($urandom_range(1023)));
            write_register(c2tot_pkg::REG_PERIOD, 24'($urandom_range(1, 2000)));
            write_register(c2tot_pkg::REG_RISE, 24'($urandom_range(4000)));
            write_register(c2tot_pkg::REG_THRESHOLD, 24'($urandom_range(50000)));
            random_phase(210);
            drain_pipeline();
        end

        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
